[rtl/rcwc_pkg.sv]
// ----------------------------------------------------------------------------
// rcwc_pkg
// Shared types and constants for the Reno congestion window controller.
// ----------------------------------------------------------------------------
package rcwc_pkg;

  localparam int SeqW      = 8;
  localparam int WinW      = 5;
  localparam int TmrW      = 16;
  localparam int DupW      = 8;
  localparam int CredW     = 5;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;

  localparam int WindowMax = 16;
  localparam int AdvMax    = 2 * WindowMax;

  localparam logic [TmrW-1:0] TimeoutReset   = TmrW'(1000);
  localparam logic [WinW-1:0] ThresholdReset = WinW'(6);
  localparam logic [WinW-1:0] ThresholdMin   = WinW'(2);
  localparam logic [DupW-1:0] DupTrigger     = DupW'(3);

  typedef enum logic {
    OpAck  = 1'b0,
    OpTick = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PhaseSlowStart = 2'd0,
    PhaseAvoid     = 2'd1,
    PhaseFastRec   = 2'd2,
    PhaseTimeout   = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTimeoutTicks = 2'd0,
    CfgInitThresh   = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    op_e             opcode;
    logic [SeqW-1:0] ack_number;
  } ev_t;

  typedef struct packed {
    logic [SeqW-1:0] window_base;
    logic [SeqW-1:0] send_limit;
    logic [WinW-1:0] cwnd;
    logic [WinW-1:0] threshold;
    logic            retransmit;
    phase_e          phase;
  } res_t;

  typedef struct packed {
    logic                valid;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

endpackage

[rtl/rcwc_in_stage.sv]
// ----------------------------------------------------------------------------
// rcwc_in_stage
// Input register: holds one event word until the update stage takes it.
// ----------------------------------------------------------------------------
module rcwc_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rcwc_pkg::ev_t ev_i,
  input  logic          advance_i,
  output logic          fire_o,
  output rcwc_pkg::ev_t ev_o
);
  import rcwc_pkg::*;

  logic valid_q;
  ev_t  ev_q;

  assign fire_o     = valid_q & advance_i;
  assign in_ready_o = ~valid_q | advance_i;
  assign ev_o       = ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ev_q <= ev_i;
    end
  end

endmodule

[rtl/rcwc_update.sv]
// ----------------------------------------------------------------------------
// rcwc_update
// Window state registers and the single-pass next-state logic per event.
// ----------------------------------------------------------------------------
module rcwc_update (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  rcwc_pkg::ev_t     ev_i,
  input  rcwc_pkg::cfg_wr_t cfg_i,
  output rcwc_pkg::res_t    res_o
);
  import rcwc_pkg::*;

  localparam logic [WinW-1:0]  WinMax  = WinW'(WindowMax);
  localparam logic [SeqW-1:0]  AdvLim  = SeqW'(AdvMax);
  localparam logic [DupW-1:0]  DupSat  = {DupW{1'b1}};
  localparam logic [CredW-1:0] CredSat = {CredW{1'b1}};
  localparam logic [TmrW-1:0]  TmrSat  = {TmrW{1'b1}};

  logic [TmrW-1:0]  timeout_q;
  logic [WinW-1:0]  win_q, win_d;
  logic [WinW-1:0]  thr_q, thr_d;
  logic [SeqW-1:0]  base_q, base_d;
  logic [SeqW-1:0]  last_q, last_d;
  logic             lastv_q, lastv_d;
  logic [DupW-1:0]  dup_q, dup_d;
  logic [CredW-1:0] cred_q, cred_d;
  logic             tof_q, tof_d;
  logic [TmrW-1:0]  tmr_q, tmr_d;
  logic             resend;

  logic [TmrW-1:0]  limit;
  logic [TmrW-1:0]  tmr_inc;
  logic [WinW-1:0]  halved;
  logic [WinW-1:0]  grown;
  logic [SeqW-1:0]  adv_dist;
  logic             adv_ok;
  logic             is_dup;
  logic [DupW-1:0]  dup_n;
  logic [CredW-1:0] cred_n;
  logic [WinW-1:0]  cfg_thr;
  phase_e           phase;

  assign limit    = (timeout_q == '0) ? TmrW'(1) : timeout_q;
  assign tmr_inc  = (tmr_q == TmrSat) ? tmr_q : tmr_q + TmrW'(1);
  assign halved   = ((win_q >> 1) > ThresholdMin) ? (win_q >> 1) : ThresholdMin;
  assign grown    = (win_q < WinMax) ? win_q + WinW'(1) : win_q;
  assign adv_dist = ev_i.ack_number - base_q;
  assign adv_ok   = (adv_dist != '0) && (adv_dist <= AdvLim);
  assign is_dup   = lastv_q && (ev_i.ack_number == last_q);
  assign dup_n    = is_dup ? ((dup_q == DupSat) ? dup_q : dup_q + DupW'(1)) : DupW'(1);
  assign cred_n   = (cred_q == CredSat) ? cred_q : cred_q + CredW'(1);
  assign cfg_thr  = (cfg_i.data[WinW-1:0] < ThresholdMin) ? ThresholdMin
                                                          : cfg_i.data[WinW-1:0];

  always_comb begin
    win_d   = win_q;
    thr_d   = thr_q;
    base_d  = base_q;
    last_d  = last_q;
    lastv_d = lastv_q;
    dup_d   = dup_q;
    cred_d  = cred_q;
    tof_d   = tof_q;
    tmr_d   = tmr_q;
    resend  = 1'b0;
    unique case (ev_i.opcode)
      OpTick: begin
        tmr_d = tmr_inc;
        if (tmr_inc >= limit) begin
          thr_d  = halved;
          win_d  = WinW'(1);
          dup_d  = DupW'(1);
          cred_d = '0;
          tmr_d  = '0;
          tof_d  = 1'b1;
          resend = 1'b1;
        end
      end
      OpAck: begin
        dup_d = dup_n;
        if (!is_dup && dup_q >= DupTrigger) begin
          // new ack closes recovery: deflate to threshold
          if (adv_ok) begin
            base_d = ev_i.ack_number;
            tmr_d  = '0;
          end
          win_d = thr_q;
          tof_d = 1'b0;
        end else if (is_dup && dup_n == DupTrigger) begin
          // fast retransmit; timeout flag stays as it is
          thr_d  = halved;
          cred_d = '0;
          tmr_d  = '0;
          resend = 1'b1;
        end else begin
          if (dup_n > DupTrigger) begin
            win_d = grown;
          end else if (adv_ok) begin
            if (win_q <= thr_q) begin
              win_d = grown;
            end else if (cred_n >= win_q && win_q < WinMax) begin
              win_d  = win_q + WinW'(1);
              cred_d = '0;
            end else begin
              cred_d = cred_n;
            end
            base_d = ev_i.ack_number;
            tmr_d  = '0;
          end
          tof_d = 1'b0;
        end
        last_d  = ev_i.ack_number;
        lastv_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    priority if (tof_d) begin
      phase = PhaseTimeout;
    end else if (dup_d >= DupTrigger) begin
      phase = PhaseFastRec;
    end else if (win_d <= thr_d) begin
      phase = PhaseSlowStart;
    end else begin
      phase = PhaseAvoid;
    end
  end

  assign res_o.window_base = base_d;
  assign res_o.send_limit  = base_d + {{(SeqW-WinW){1'b0}}, win_d};
  assign res_o.cwnd        = win_d;
  assign res_o.threshold   = thr_d;
  assign res_o.retransmit  = resend;
  assign res_o.phase       = phase;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
      win_q     <= WinW'(1);
      thr_q     <= ThresholdReset;
      base_q    <= '0;
      last_q    <= '0;
      lastv_q   <= 1'b0;
      dup_q     <= DupW'(1);
      cred_q    <= '0;
      tof_q     <= 1'b0;
      tmr_q     <= '0;
    end else if (fire_i) begin
      win_q   <= win_d;
      thr_q   <= thr_d;
      base_q  <= base_d;
      last_q  <= last_d;
      lastv_q <= lastv_d;
      dup_q   <= dup_d;
      cred_q  <= cred_d;
      tof_q   <= tof_d;
      tmr_q   <= tmr_d;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgTimeoutTicks: timeout_q <= cfg_i.data[TmrW-1:0];
        CfgInitThresh:   thr_q     <= cfg_thr;
        default: ;
      endcase
    end
  end

endmodule

[rtl/rcwc_out_stage.sv]
// ----------------------------------------------------------------------------
// rcwc_out_stage
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module rcwc_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  rcwc_pkg::res_t res_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rcwc_pkg::res_t res_o
);
  import rcwc_pkg::*;

  logic valid_q;
  res_t res_q;

  assign free_o      = ~valid_q | out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

[rtl/reno_congestion_window_controller_core.sv]
// ----------------------------------------------------------------------------
// reno_congestion_window_controller_core
// Reno-style sender window controller driven by ack and timer-tick events.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid_i/in_ready_o  | opcode_i, ack_number_i
//  out     | output    | out_valid_o/out_ready_i| window_base_o .. phase_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One event word per cycle while the output drains; the result word is valid
// in the cycle after the edge that moves the word out of the input register
// (input register, then state update into the result register).
// The state update is a single pass of compares and small adds per event.
// Reset loads timeout 1000 ticks, threshold 6, window 1, base 0.
// A stalled output holds its word; the input side keeps taking words while
// the result register is free or being drained in the same cycle. A register
// write waits while an event word is being processed.
// ----------------------------------------------------------------------------
module reno_congestion_window_controller_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            opcode_i,
  input  logic [rcwc_pkg::SeqW-1:0]       ack_number_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rcwc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rcwc_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rcwc_pkg::SeqW-1:0]       window_base_o,
  output logic [rcwc_pkg::SeqW-1:0]       send_limit_o,
  output logic [rcwc_pkg::WinW-1:0]       cwnd_o,
  output logic [rcwc_pkg::WinW-1:0]       threshold_o,
  output logic                            retransmit_o,
  output logic [1:0]                      phase_o
);
  import rcwc_pkg::*;

  ev_t     ev_in, ev_held;
  res_t    res_next, res_out;
  cfg_wr_t cfg_wr;
  logic    fire;
  logic    out_free;

  assign ev_in.opcode     = op_e'(opcode_i);
  assign ev_in.ack_number = ack_number_i;

  // hold a register write while an event updates the state
  assign cfg_ready_o  = ~fire;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  rcwc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .ev_i       (ev_in),
    .advance_i  (out_free),
    .fire_o     (fire),
    .ev_o       (ev_held)
  );

  rcwc_update u_upd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .ev_i   (ev_held),
    .cfg_i  (cfg_wr),
    .res_o  (res_next)
  );

  rcwc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_i       (res_next),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign window_base_o = res_out.window_base;
  assign send_limit_o  = res_out.send_limit;
  assign cwnd_o        = res_out.cwnd;
  assign threshold_o   = res_out.threshold;
  assign retransmit_o  = res_out.retransmit;
  assign phase_o       = res_out.phase;

endmodule

[rtl/rcwc_checker.sv]
// ----------------------------------------------------------------------------
// rcwc_checker
// Port-level checks for the window controller, bound to the top level.
// ----------------------------------------------------------------------------
module rcwc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [rcwc_pkg::SeqW-1:0] window_base_o,
  input logic [rcwc_pkg::SeqW-1:0] send_limit_o,
  input logic [rcwc_pkg::WinW-1:0] cwnd_o,
  input logic [rcwc_pkg::WinW-1:0] threshold_o,
  input logic                      retransmit_o,
  input logic [1:0]                phase_o
);
  import rcwc_pkg::*;

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(window_base_o)
      && $stable(cwnd_o) && $stable(phase_o))
    else $error("output word changed while stalled");

  a_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> send_limit_o == SeqW'(window_base_o + SeqW'(cwnd_o)))
    else $error("send limit is not base plus window");

  a_window_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cwnd_o != '0 && threshold_o >= ThresholdMin)
    else $error("window or threshold below floor");

  // a resend only comes out of fast retransmit or timeout
  a_resend_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && retransmit_o |->
      phase_o == PhaseFastRec || phase_o == PhaseTimeout)
    else $error("retransmit outside recovery");

endmodule

bind reno_congestion_window_controller_core rcwc_checker u_rcwc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .window_base_o (window_base_o),
  .send_limit_o  (send_limit_o),
  .cwnd_o        (cwnd_o),
  .threshold_o   (threshold_o),
  .retransmit_o  (retransmit_o),
  .phase_o       (phase_o)
);
